// ===== design/cgsa_pkg.sv =====
// shared widths, register codes and stage types of the complex gram slice accumulator
package cgsa_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int PSUM_W      = PROD_W + 1;
    localparam int DOT_W       = 41;
    localparam int SLICE_W     = 24;
    localparam int SQ_W        = 2 * SLICE_W - 1;
    localparam int GRP_W       = 28;
    localparam int NORM_W      = 52;
    localparam int DOT_SHIFT_W = 5;
    localparam int OUT_SHIFT_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_TDATA_W  = 4 * SAMPLE_W;
    localparam int OUT_TDATA_W = 112;

    localparam logic [DOT_SHIFT_W-1:0] DOT_SHIFT_RST = 5'd16;
    localparam logic [OUT_SHIFT_W-1:0] OUT_SHIFT_RST = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_SHIFT = 1'b0,
        REG_OUT_SHIFT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                       valid;
        logic                       grp_end;
        logic signed [SLICE_W-1:0]  re;
        logic signed [SLICE_W-1:0]  im;
    } slice_res_t;

    typedef struct packed {
        logic                       valid;
        logic [NORM_W-1:0]          norm;
        logic signed [GRP_W-1:0]    re;
        logic signed [GRP_W-1:0]    im;
    } grp_res_t;

endpackage

// ===== design/cgsa_slice.sv =====
// input register, conjugate products, slice accumulation, scaling and saturation
module cgsa_slice
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_req,
    input  logic signed [cgsa_pkg::SAMPLE_W-1:0]   left_re,
    input  logic signed [cgsa_pkg::SAMPLE_W-1:0]   left_im,
    input  logic signed [cgsa_pkg::SAMPLE_W-1:0]   right_re,
    input  logic signed [cgsa_pkg::SAMPLE_W-1:0]   right_im,
    input  logic                                   last_in_slice,
    input  logic                                   last_in_group,
    input  logic [cgsa_pkg::DOT_SHIFT_W-1:0]       dot_shift,
    output cgsa_pkg::slice_res_t                   slice_res
);

    localparam int DOT_W   = cgsa_pkg::DOT_W;
    localparam int PROD_W  = cgsa_pkg::PROD_W;
    localparam int PSUM_W  = cgsa_pkg::PSUM_W;
    localparam int SLICE_W = cgsa_pkg::SLICE_W;

    // input stage
    logic                                  a_valid_reg;
    logic                                  a_close_reg;
    logic                                  a_grp_reg;
    logic signed [cgsa_pkg::SAMPLE_W-1:0]  a_lr_reg, a_li_reg, a_rr_reg, a_ri_reg;

    // product stage
    logic                                  b_valid_reg;
    logic                                  b_close_reg;
    logic                                  b_grp_reg;
    logic signed [PROD_W-1:0]              b_rr_reg, b_ii_reg, b_ri_reg, b_ir_reg;

    // slice accumulators and closed slice sums
    logic signed [DOT_W-1:0]               dot_real_reg, dot_imag_reg;
    logic signed [DOT_W-1:0]               dot_real_next, dot_imag_next;
    logic                                  c_valid_reg;
    logic                                  c_grp_reg;
    logic signed [DOT_W-1:0]               c_real_reg, c_imag_reg;

    logic signed [PSUM_W-1:0]              psum_re, psum_im;
    logic signed [DOT_W-1:0]               shr_re, shr_im;
    logic signed [SLICE_W-1:0]             sat_re, sat_im;

    logic                                  d_valid_reg;
    logic                                  d_grp_reg;
    logic signed [SLICE_W-1:0]             d_re_reg, d_im_reg;

    function automatic logic signed [SLICE_W-1:0] sat_slice(input logic signed [DOT_W-1:0] x);
        logic signed [SLICE_W-1:0] r;
        if (x[DOT_W-1:SLICE_W-1] == '0 || x[DOT_W-1:SLICE_W-1] == '1)
        begin
            r = x[SLICE_W-1:0];
        end
        else if (x[DOT_W-1])
        begin
            r = {1'b1, {(SLICE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SLICE_W-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        psum_re = {b_rr_reg[PROD_W-1], b_rr_reg} + {b_ii_reg[PROD_W-1], b_ii_reg};
        psum_im = {b_ri_reg[PROD_W-1], b_ri_reg} - {b_ir_reg[PROD_W-1], b_ir_reg};
        dot_real_next = dot_real_reg + {{(DOT_W-PSUM_W){psum_re[PSUM_W-1]}}, psum_re};
        dot_imag_next = dot_imag_reg + {{(DOT_W-PSUM_W){psum_im[PSUM_W-1]}}, psum_im};
        shr_re = c_real_reg >>> dot_shift;
        shr_im = c_imag_reg >>> dot_shift;
        sat_re = sat_slice(shr_re);
        sat_im = sat_slice(shr_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            dot_real_reg <= '0;
            dot_imag_reg <= '0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_req;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_close_reg;
            d_valid_reg <= c_valid_reg;
            if (b_valid_reg)
            begin
                if (b_close_reg)
                begin
                    dot_real_reg <= '0;
                    dot_imag_reg <= '0;
                end
                else
                begin
                    dot_real_reg <= dot_real_next;
                    dot_imag_reg <= dot_imag_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_lr_reg      <= left_re;
            a_li_reg      <= left_im;
            a_rr_reg      <= right_re;
            a_ri_reg      <= right_im;
            a_close_reg   <= last_in_slice | last_in_group;
            a_grp_reg     <= last_in_group;
            b_rr_reg      <= PROD_W'(a_lr_reg) * PROD_W'(a_rr_reg);
            b_ii_reg      <= PROD_W'(a_li_reg) * PROD_W'(a_ri_reg);
            b_ri_reg      <= PROD_W'(a_lr_reg) * PROD_W'(a_ri_reg);
            b_ir_reg      <= PROD_W'(a_li_reg) * PROD_W'(a_rr_reg);
            b_close_reg   <= a_close_reg;
            b_grp_reg     <= a_grp_reg;
            c_real_reg    <= dot_real_next;
            c_imag_reg    <= dot_imag_next;
            c_grp_reg     <= b_grp_reg;
            d_re_reg      <= sat_re;
            d_im_reg      <= sat_im;
            d_grp_reg     <= c_grp_reg;
        end
    end

    assign slice_res = '{valid: d_valid_reg, grp_end: d_grp_reg, re: d_re_reg, im: d_im_reg};

    // a closing row leaves the slice accumulators cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && b_valid_reg && b_close_reg |=> dot_real_reg == '0 && dot_imag_reg == '0)
        else $error("slice accumulators not cleared at slice close");

endmodule

// ===== design/cgsa_group.sv =====
// squared magnitudes and saturating group accumulation
module cgsa_group
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  cgsa_pkg::slice_res_t   slice_res,
    output cgsa_pkg::grp_res_t     grp_res
);

    localparam int SLICE_W = cgsa_pkg::SLICE_W;
    localparam int SQ_W    = cgsa_pkg::SQ_W;
    localparam int GRP_W   = cgsa_pkg::GRP_W;
    localparam int NORM_W  = cgsa_pkg::NORM_W;

    logic                              e_valid_reg;
    logic                              e_grp_reg;
    logic signed [SLICE_W-1:0]         e_re_reg, e_im_reg;
    logic [SQ_W-1:0]                   e_sq_re_reg, e_sq_im_reg;
    logic signed [2*SLICE_W-1:0]       sq_re_full, sq_im_full;

    logic signed [GRP_W-1:0]           group_real_reg, group_imag_reg;
    logic [NORM_W-1:0]                 group_norm_reg;
    logic signed [GRP_W-1:0]           group_real_next, group_imag_next;
    logic [NORM_W-1:0]                 group_norm_next;
    logic signed [GRP_W:0]             sum_re, sum_im;
    logic [NORM_W:0]                   sum_norm;

    logic                              res_valid_reg;
    logic [NORM_W-1:0]                 res_norm_reg;
    logic signed [GRP_W-1:0]           res_re_reg, res_im_reg;

    function automatic logic signed [GRP_W-1:0] sat_grp(input logic signed [GRP_W:0] x);
        logic signed [GRP_W-1:0] r;
        if (x[GRP_W] == x[GRP_W-1])
        begin
            r = x[GRP_W-1:0];
        end
        else if (x[GRP_W])
        begin
            r = {1'b1, {(GRP_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(GRP_W-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        sq_re_full = (2*SLICE_W)'(slice_res.re) * (2*SLICE_W)'(slice_res.re);
        sq_im_full = (2*SLICE_W)'(slice_res.im) * (2*SLICE_W)'(slice_res.im);
        sum_re = {group_real_reg[GRP_W-1], group_real_reg}
               + {{(GRP_W+1-SLICE_W){e_re_reg[SLICE_W-1]}}, e_re_reg};
        sum_im = {group_imag_reg[GRP_W-1], group_imag_reg}
               + {{(GRP_W+1-SLICE_W){e_im_reg[SLICE_W-1]}}, e_im_reg};
        sum_norm = {1'b0, group_norm_reg}
                 + {{(NORM_W+1-SQ_W){1'b0}}, e_sq_re_reg}
                 + {{(NORM_W+1-SQ_W){1'b0}}, e_sq_im_reg};
        group_real_next = sat_grp(sum_re);
        group_imag_next = sat_grp(sum_im);
        group_norm_next = sum_norm[NORM_W] ? '1 : sum_norm[NORM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            group_real_reg <= '0;
            group_imag_reg <= '0;
            group_norm_reg <= '0;
        end
        else if (adv)
        begin
            e_valid_reg   <= slice_res.valid;
            res_valid_reg <= e_valid_reg && e_grp_reg;
            if (e_valid_reg)
            begin
                if (e_grp_reg)
                begin
                    group_real_reg <= '0;
                    group_imag_reg <= '0;
                    group_norm_reg <= '0;
                end
                else
                begin
                    group_real_reg <= group_real_next;
                    group_imag_reg <= group_imag_next;
                    group_norm_reg <= group_norm_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_re_reg     <= slice_res.re;
            e_im_reg     <= slice_res.im;
            e_grp_reg    <= slice_res.grp_end;
            e_sq_re_reg  <= sq_re_full[SQ_W-1:0];
            e_sq_im_reg  <= sq_im_full[SQ_W-1:0];
            res_re_reg   <= group_real_next;
            res_im_reg   <= group_imag_next;
            res_norm_reg <= group_norm_next;
        end
    end

    assign grp_res = '{valid: res_valid_reg, norm: res_norm_reg, re: res_re_reg, im: res_im_reg};

    // a group close hands one result forward and leaves the group sums cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && e_valid_reg && e_grp_reg |=> res_valid_reg && group_real_reg == '0
            && group_imag_reg == '0 && group_norm_reg == '0)
        else $error("group close did not produce a result and clear the sums");

    // without a group close no result appears
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && !(e_valid_reg && e_grp_reg) |=> !res_valid_reg)
        else $error("result without a group close");

endmodule

// ===== design/cgsa_out.sv =====
// output scaling and output register
module cgsa_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  cgsa_pkg::grp_res_t                 grp_res,
    input  logic [cgsa_pkg::OUT_SHIFT_W-1:0]   out_shift,
    input  logic                               m_axis_tready,
    output logic                               m_axis_tvalid,
    output logic [cgsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int GRP_W  = cgsa_pkg::GRP_W;
    localparam int NORM_W = cgsa_pkg::NORM_W;
    localparam int PAD_W  = cgsa_pkg::OUT_TDATA_W - NORM_W - 2 * GRP_W;

    logic                      out_valid_reg;
    logic [NORM_W-1:0]         norm_reg;
    logic signed [GRP_W-1:0]   re_reg, im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            norm_reg <= grp_res.norm >> out_shift;
            re_reg   <= grp_res.re >>> out_shift;
            im_reg   <= grp_res.im >>> out_shift;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, im_reg, re_reg, norm_reg};

endmodule

// ===== design/complex_gram_slice_accumulator_top.sv =====
// top level of the complex gram slice accumulator
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata samples, tuser slice end, tlast group end
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata norm_sum, re_sum, im_sum
//  cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// one request per cycle while s_axis_tready is high
// the input register takes the request; product, slice, scale, square, group and output follow
// reset clears the accumulators and loads dot_shift 16 and out_shift 4; cfg_ready is always high
// the pipeline stalls only while a finished result waits behind an occupied output register
module complex_gram_slice_accumulator_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [cgsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // left_re, left_im, right_re, right_im
    input  logic                                 s_axis_tuser,  // last_in_slice
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [cgsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // norm_sum, re_sum, im_sum, zero pad
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cgsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cgsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SAMPLE_W = cgsa_pkg::SAMPLE_W;

    logic [cgsa_pkg::DOT_SHIFT_W-1:0]  dot_shift_reg;
    logic [cgsa_pkg::OUT_SHIFT_W-1:0]  out_shift_reg;
    logic                              adv;
    logic                              in_req;
    cgsa_pkg::slice_res_t              slice_res;
    cgsa_pkg::grp_res_t                grp_res;

    // hold everything only while a result waits on a full output register
    assign adv           = !(grp_res.valid && m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = adv;
    assign in_req        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_shift_reg <= cgsa_pkg::DOT_SHIFT_RST;
            out_shift_reg <= cgsa_pkg::OUT_SHIFT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cgsa_pkg::cfg_reg_t'(cfg_index))
                cgsa_pkg::REG_DOT_SHIFT: dot_shift_reg <= cfg_data[cgsa_pkg::DOT_SHIFT_W-1:0];
                cgsa_pkg::REG_OUT_SHIFT: out_shift_reg <= cfg_data[cgsa_pkg::OUT_SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    cgsa_slice u_slice
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_req        (in_req),
        .left_re       (s_axis_tdata[SAMPLE_W-1:0]),
        .left_im       (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .right_re      (s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .right_im      (s_axis_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
        .last_in_slice (s_axis_tuser),
        .last_in_group (s_axis_tlast),
        .dot_shift     (dot_shift_reg),
        .slice_res     (slice_res)
    );

    cgsa_group u_group
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .slice_res (slice_res),
        .grp_res   (grp_res)
    );

    cgsa_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (grp_res.valid && adv),
        .grp_res       (grp_res),
        .out_shift     (out_shift_reg),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

    // input is refused only while a result is waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && grp_res.valid)
        else $error("input stalled without a waiting result");

endmodule
